>>> hdl/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

	localparam int NUM_BUTTONS_DEF = 4;

	// Widths fixed by the item format
	localparam int CNT_W   = 16;
	localparam int CLS_W   = 3;
	localparam int CMD_W   = 2;
	localparam int BTN_W   = 2;
	localparam int CIDX_W  = 3;
	localparam int IN_W    = 8;
	localparam int OUT_W   = 8;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CLS_W-1:0] cls_t;

	localparam cnt_t HOLD_MAX = '1;

	// Press classes
	localparam cls_t CLS_NONE       = 3'd0;
	localparam cls_t CLS_SHORT      = 3'd1;
	localparam cls_t CLS_LONG       = 3'd2;
	localparam cls_t CLS_VLONG      = 3'd3;
	localparam cls_t CLS_WAIT_SHORT = 3'd4;
	localparam cls_t CLS_WAIT_LONG  = 3'd5;
	localparam cls_t CLS_WAIT_VLONG = 3'd6;
	localparam cls_t CLS_WAIT_OFS   = CLS_WAIT_SHORT - CLS_SHORT;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_PEEK  = 2'd3
	} cmd_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_SHORT_THR = 3'd0,
		REG_LONG_THR  = 3'd1,
		REG_VLONG_THR = 3'd2,
		REG_TIMEOUT   = 3'd3,
		REG_IDLE_LVL  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		cnt_t short_thr;
		cnt_t long_thr;
		cnt_t vlong_thr;
		cnt_t timeout;
		logic idle_level;
	} cfg_t;

	localparam cnt_t RST_SHORT_THR = 16'd5;
	localparam cnt_t RST_LONG_THR  = 16'd100;
	localparam cnt_t RST_VLONG_THR = 16'd300;
	localparam cnt_t RST_TIMEOUT   = 16'd50;
	localparam logic RST_IDLE_LVL  = 1'b1;

endpackage
`default_nettype wire

>>> hdl/bpc_core.sv
`default_nettype none
module bpc_core #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire bpc_pkg::cmd_t              cmd,
	input  wire logic [bpc_pkg::BTN_W-1:0]  button,
	input  wire logic                       level,
	input  wire bpc_pkg::cfg_t              cfg,
	output bpc_pkg::cls_t                   rep
);
	import bpc_pkg::*;

	localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	cnt_t hold_q    [NUM_BUTTONS];
	cnt_t timeout_q [NUM_BUTTONS];
	cls_t class_q   [NUM_BUTTONS];
	logic ack_q     [NUM_BUTTONS];

	logic [IDX_W-1:0] sel;
	logic             in_range;
	cnt_t             h, t, nh, nt, hinc;
	cls_t             c, nc;
	logic             a, na;

	assign sel      = IDX_W'(button);
	assign in_range = (32'(button) < 32'(NUM_BUTTONS));

	always_comb begin
		h    = hold_q[sel];
		t    = timeout_q[sel];
		c    = class_q[sel];
		a    = ack_q[sel];
		nh   = h;
		nt   = t;
		nc   = c;
		na   = a;
		rep  = CLS_NONE;
		hinc = (h == HOLD_MAX) ? h : h + 16'd1;
		if (in_range) begin
			case (cmd)
				CMD_TICK: begin
					if (level == cfg.idle_level) begin
						// release: classify the hold just ended
						if (h >= cfg.short_thr && h < cfg.long_thr) begin
							nc = CLS_SHORT;
							nt = cfg.timeout;
						end
						if (h >= cfg.long_thr && h < cfg.vlong_thr) begin
							nc = CLS_LONG;
							nt = cfg.timeout;
						end
						nh = '0;
						nt = nt - 16'd1;
						if (nt == '0 || a) begin
							nc = CLS_NONE;
							na = 1'b0;
						end
					end else begin
						// hold: extend and promote
						nh = hinc;
						if (!a && hinc >= cfg.long_thr) begin
							nc = CLS_LONG;
							nt = cfg.timeout;
						end
						if (nc == CLS_WAIT_LONG && hinc >= cfg.vlong_thr) begin
							nc = CLS_VLONG;
							nt = cfg.timeout;
						end
					end
					rep = nc;
				end
				CMD_READ: begin
					rep = c;
					if (c inside {[CLS_SHORT:CLS_VLONG]}) begin
						na = 1'b1;
						nc = c + CLS_WAIT_OFS;
					end
				end
				CMD_CLEAR: begin
					nc  = CLS_NONE;
					na  = 1'b1;
					rep = CLS_NONE;
				end
				default: begin
					rep = c;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				hold_q[i]    <= '0;
				timeout_q[i] <= '0;
				class_q[i]   <= CLS_NONE;
				ack_q[i]     <= 1'b1;
			end
		end else if (en && in_range) begin
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				if (sel == IDX_W'(i)) begin
					hold_q[i]    <= nh;
					timeout_q[i] <= nt;
					class_q[i]   <= nc;
					ack_q[i]     <= na;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/button_press_classifier.sv
`default_nettype none
// Short / long / very long press classifier for NUM_BUTTONS push buttons. Each input beat
// addresses one button and carries a command in s_axis_tuser (sample tick with the pin
// level, read of the press result, clear, peek at the result without acknowledging it) and
// the button index and level in s_axis_tdata. Every input beat gives exactly one output
// beat with the reported class and the button index. The block takes one beat per clock
// cycle, back to back, while the output side is not stalled. Each beat passes through the
// input register and then the result register; the per-button read-modify-write of hold
// counter, timeout counter, class and acknowledge flag is done combinationally between
// them, so consecutive beats on the same button need no forwarding. Thresholds, report
// timeout and idle level are written through the cfg_* port, which is always ready; write
// them only while no beat is in flight. Button indexes at or above NUM_BUTTONS leave all
// state alone and report class none.
module button_press_classifier #(
	parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// config write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [bpc_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [bpc_pkg::CNT_W-1:0]   cfg_data,
	// input stream
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [bpc_pkg::IN_W-1:0]    s_axis_tdata,  // [1:0] button_index, [2] level
	input  wire logic [bpc_pkg::CMD_W-1:0]   s_axis_tuser,  // [1:0] command
	// result stream
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [bpc_pkg::OUT_W-1:0]        m_axis_tdata   // [2:0] reported_state, [4:3] button_echo
);
	import bpc_pkg::*;

	cfg_t              cfg_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [BTN_W-1:0]  button_s1;
	logic              level_s1;

	logic              valid_s2;
	cls_t              rep_s2;
	logic [BTN_W-1:0]  echo_s2;

	logic              out_free;
	logic              advance;
	cls_t              rep;

	// Config registers: always ready, writes beyond the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_thr  <= RST_SHORT_THR;
			cfg_q.long_thr   <= RST_LONG_THR;
			cfg_q.vlong_thr  <= RST_VLONG_THR;
			cfg_q.timeout    <= RST_TIMEOUT;
			cfg_q.idle_level <= RST_IDLE_LVL;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SHORT_THR: cfg_q.short_thr  <= cfg_data;
				REG_LONG_THR:  cfg_q.long_thr   <= cfg_data;
				REG_VLONG_THR: cfg_q.vlong_thr  <= cfg_data;
				REG_TIMEOUT:   cfg_q.timeout    <= cfg_data;
				REG_IDLE_LVL:  cfg_q.idle_level <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Handshake: the result register frees when empty or taken this cycle; the input
	// register advances into it then, and takes a new beat whenever it empties.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1    <= cmd_t'(s_axis_tuser);
			button_s1 <= s_axis_tdata[BTN_W-1:0];
			level_s1  <= s_axis_tdata[BTN_W];
		end
	end

	// Per-button state update, committed as the beat advances
	bpc_core #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd_s1),
		.button (button_s1),
		.level  (level_s1),
		.cfg    (cfg_q),
		.rep    (rep)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rep_s2  <= rep;
			echo_s2 <= button_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(OUT_W - CLS_W - BTN_W)'(0), echo_s2, rep_s2};

endmodule
`default_nettype wire

>>> hdl/bpc_checker.sv
`default_nettype none
module bpc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_axis_tvalid,
	input wire logic                        s_axis_tready,
	input wire logic                        m_axis_tvalid,
	input wire logic                        m_axis_tready,
	input wire logic [bpc_pkg::OUT_W-1:0]   m_axis_tdata
);
	import bpc_pkg::*;

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// class field never carries an undefined code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[CLS_W-1:0] <= CLS_WAIT_VLONG)
		else $error("reported class out of range");

	// padding above the fields stays zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_W-1:CLS_W+BTN_W] == '0)
		else $error("result padding not zero");

	// a beat taken while the result stream is idle yields a valid result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
		else $error("accepted beat produced no result");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
